### sv/mlwq_pkg.sv
package mlwq_pkg;

   // Built maximum of priority levels, and field widths of the request and response
   localparam int MAX_LEVELS          = 8;
   localparam int LEVEL_WIDTH         = 3;
   localparam int ITEM_WIDTH          = 32;
   localparam int TOTAL_WIDTH         = 8;
   localparam int LEVELS_USED_WIDTH   = 4;
   localparam int LEVELS_USED_RESET   = 8;
   localparam int LEVEL_DEPTH_DEFAULT = 16;

   typedef enum logic [0:0] {
      ACT_ENQUEUE = 1'b0,
      ACT_DEQUEUE = 1'b1
   } mlwq_action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } mlwq_status_type;

   typedef struct packed {
      mlwq_action_type         action;
      logic [LEVEL_WIDTH-1:0]  level;
      logic [ITEM_WIDTH-1:0]   item_in;
   } mlwq_req_type;

   typedef struct packed {
      mlwq_status_type         status;
      logic [LEVEL_WIDTH-1:0]  found_level;
      logic [ITEM_WIDTH-1:0]   item_out;
      logic [TOTAL_WIDTH-1:0]  total_count;
   } mlwq_rsp_type;

   // Store access issued by the control unit
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mlwq_mem_cmd_type;

endpackage

### sv/mlwq_store.sv
module mlwq_store
   import mlwq_pkg::*;
#(
   parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEFAULT,
   localparam int PTR_WIDTH  = $clog2(LEVEL_DEPTH),
   localparam int ADDR_WIDTH = LEVEL_WIDTH + PTR_WIDTH
) (
   input  logic                   clock,
   input  mlwq_mem_cmd_type       mem_cmd,
   input  logic [ADDR_WIDTH-1:0]  mem_addr,
   input  logic [ITEM_WIDTH-1:0]  wr_data,
   output logic [ITEM_WIDTH-1:0]  rd_data
);

   localparam int STORE_DEPTH = 2 ** ADDR_WIDTH;

   logic [ITEM_WIDTH-1:0] store_mem [STORE_DEPTH];
   logic [ITEM_WIDTH-1:0] rd_data_ff;

   // Write the appended handle
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         store_mem[mem_addr] <= wr_data;
      end
   end

   // Read the head handle into a registered output
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/mlwq_ctrl.sv
module mlwq_ctrl
   import mlwq_pkg::*;
#(
   parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEFAULT,
   localparam int PTR_WIDTH  = $clog2(LEVEL_DEPTH),
   localparam int ADDR_WIDTH = LEVEL_WIDTH + PTR_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  mlwq_req_type                  req,
   input  logic [LEVELS_USED_WIDTH-1:0]  levels_used,
   output mlwq_mem_cmd_type              mem_cmd,
   output logic [ADDR_WIDTH-1:0]         mem_addr,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output mlwq_rsp_type                  rsp_meta
);

   localparam int COUNT_WIDTH = $clog2(LEVEL_DEPTH + 1);
   localparam int SUM_WIDTH   = $clog2(MAX_LEVELS * LEVEL_DEPTH + 1);

   logic [PTR_WIDTH-1:0]   head_ff  [MAX_LEVELS];
   logic [PTR_WIDTH-1:0]   head_in  [MAX_LEVELS];
   logic [PTR_WIDTH-1:0]   tail_ff  [MAX_LEVELS];
   logic [PTR_WIDTH-1:0]   tail_in  [MAX_LEVELS];
   logic [COUNT_WIDTH-1:0] count_ff [MAX_LEVELS];
   logic [COUNT_WIDTH-1:0] count_in [MAX_LEVELS];
   logic [SUM_WIDTH-1:0]   total_ff;
   logic [SUM_WIDTH-1:0]   total_in;

   logic                   rsp_valid_ff;
   logic                   hit_ff;
   logic                   hit_in;
   mlwq_status_type        status_ff;
   mlwq_status_type        status_in;
   logic [LEVEL_WIDTH-1:0] found_ff;
   logic [LEVEL_WIDTH-1:0] found_in;

   logic [LEVELS_USED_WIDTH-1:0] active_levels;
   logic [MAX_LEVELS-1:0]        nonempty;
   logic                         in_range;
   logic                         level_full;
   logic                         hi_hit;
   logic                         lo_hit;
   logic [LEVEL_WIDTH-1:0]       hi_idx;
   logic [LEVEL_WIDTH-1:0]       lo_idx;
   logic [LEVEL_WIDTH-1:0]       found_idx;
   logic                         deq_hit;

   // Clamp the level register to 1..MAX_LEVELS
   always_comb begin
      priority if (levels_used == '0) begin
         active_levels = LEVELS_USED_WIDTH'(1);
      end else if (levels_used > LEVELS_USED_WIDTH'(MAX_LEVELS)) begin
         active_levels = LEVELS_USED_WIDTH'(MAX_LEVELS);
      end else begin
         active_levels = levels_used;
      end
   end

   assign in_range   = {1'b0, req.level} < active_levels;
   assign level_full = count_ff[req.level] >= COUNT_WIDTH'(LEVEL_DEPTH);

   // Flag levels in use that hold at least one handle
   always_comb begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
         nonempty[k] = (count_ff[k] != '0) && (LEVELS_USED_WIDTH'(k) < active_levels);
      end
   end

   // Rotating priority encoder: first level at or above start, else first from level 0
   always_comb begin
      hi_hit = 1'b0;
      lo_hit = 1'b0;
      hi_idx = '0;
      lo_idx = '0;
      for (int k = MAX_LEVELS - 1; k >= 0; k--) begin
         if (nonempty[k]) begin
            if (LEVEL_WIDTH'(k) >= req.level) begin
               hi_hit = 1'b1;
               hi_idx = LEVEL_WIDTH'(k);
            end else begin
               lo_hit = 1'b1;
               lo_idx = LEVEL_WIDTH'(k);
            end
         end
      end
   end

   assign deq_hit   = hi_hit || lo_hit;
   assign found_idx = hi_hit ? hi_idx : lo_idx;

   // Decide the operation and advance pointers and counts
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      status_in = ST_OK;
      found_in  = '0;
      hit_in    = 1'b0;
      mem_cmd   = '0;
      mem_addr  = {req.level, tail_ff[req.level]};
      if (accept) begin
         priority if (!in_range) begin
            status_in = ST_RANGE;
         end else if (req.action == ACT_ENQUEUE) begin
            if (level_full) begin
               status_in = ST_FULL;
            end else begin
               mem_cmd.wr_en       = 1'b1;
               mem_addr            = {req.level, tail_ff[req.level]};
               tail_in[req.level]  = (tail_ff[req.level] == PTR_WIDTH'(LEVEL_DEPTH - 1))
                                     ? '0 : tail_ff[req.level] + PTR_WIDTH'(1);
               count_in[req.level] = count_ff[req.level] + COUNT_WIDTH'(1);
               total_in            = total_ff + SUM_WIDTH'(1);
            end
         end else if (deq_hit) begin
            mem_cmd.rd_en       = 1'b1;
            mem_addr            = {found_idx, head_ff[found_idx]};
            head_in[found_idx]  = (head_ff[found_idx] == PTR_WIDTH'(LEVEL_DEPTH - 1))
                                  ? '0 : head_ff[found_idx] + PTR_WIDTH'(1);
            count_in[found_idx] = count_ff[found_idx] - COUNT_WIDTH'(1);
            total_in            = total_ff - SUM_WIDTH'(1);
            found_in            = found_idx;
            hit_in              = 1'b1;
         end else begin
            status_in = ST_EMPTY;
         end
      end
   end

   // Hold per-level pointers, counts and the response flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_LEVELS; k++) begin
            head_ff[k]  <= '0;
            tail_ff[k]  <= '0;
            count_ff[k] <= '0;
         end
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= accept;
         hit_ff       <= hit_in;
      end
   end

   // Capture the response fields of the accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = hit_ff;
   assign rsp_meta.status      = status_ff;
   assign rsp_meta.found_level = found_ff;
   assign rsp_meta.item_out    = '0;
   assign rsp_meta.total_count = TOTAL_WIDTH'(total_ff);

endmodule

### sv/multilevel_wrap_queue.sv
// Multilevel queue of item handles, one FIFO per priority level.
// Request channel: drive req_payload and raise start; the beat is taken at a
// rising edge with start high and busy low. An enqueue appends item_in at the
// given level; a dequeue searches upward from the given level, wrapping at the
// last level in use, and pops the first non-empty FIFO.
// Response channel: rsp_valid strobes for one cycle with rsp_payload, in the
// cycle after the request beat. The receiver cannot stall; every response
// must be taken in its cycle.
// Throughput: one request per cycle while busy is low. Each request makes one access to the
// single-port handle store (write on enqueue, read on dequeue), and the per-
// level pointers update in the same cycle, so the next request sees them.
// Configuration: csr_data sets the number of levels in use (0 acts as 1, above
// the built maximum acts as the maximum). Write it only while idle.
// Reset: synchronous; clears all pointers, counts and the total, sets the
// level register to 8, and holds busy high while reset is asserted and, as busy
// is a register of reset, in the cycle after it. The handle store is not cleared and needs no clearing pass.
module multilevel_wrap_queue
   import mlwq_pkg::*;
#(
   parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  mlwq_req_type                  req_payload,
   output logic                          rsp_valid,
   output mlwq_rsp_type                  rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [LEVELS_USED_WIDTH-1:0]  csr_data
);

   localparam int PTR_WIDTH  = $clog2(LEVEL_DEPTH);
   localparam int ADDR_WIDTH = LEVEL_WIDTH + PTR_WIDTH;

   logic                         busy_ff;
   logic [LEVELS_USED_WIDTH-1:0] levels_used_ff;
   logic                         accept;
   mlwq_mem_cmd_type             mem_cmd;
   logic [ADDR_WIDTH-1:0]        mem_addr;
   logic [ITEM_WIDTH-1:0]        rd_data;
   logic                         rsp_hit;
   mlwq_rsp_type                 rsp_meta;

   // Hold off requests and writes during reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;
   assign accept    = start && !busy_ff;

   // Level count register
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_used_ff <= LEVELS_USED_WIDTH'(LEVELS_USED_RESET);
      end else if (csr_valid && csr_ready) begin
         levels_used_ff <= csr_data;
      end
   end

   mlwq_ctrl #(
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_payload),
      .levels_used (levels_used_ff),
      .mem_cmd     (mem_cmd),
      .mem_addr    (mem_addr),
      .rsp_valid   (rsp_valid),
      .rsp_hit     (rsp_hit),
      .rsp_meta    (rsp_meta)
   );

   mlwq_store #(
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_store (
      .clock    (clock),
      .mem_cmd  (mem_cmd),
      .mem_addr (mem_addr),
      .wr_data  (req_payload.item_in),
      .rd_data  (rd_data)
   );

   // Merge the popped handle into the response
   always_comb begin
      rsp_payload          = rsp_meta;
      rsp_payload.item_out = rsp_hit ? rd_data : '0;
   end

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response missing one cycle after request beat");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept))
      else $error("response without a request beat");

   a_fail_no_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_OK) |->
         (rsp_payload.item_out == '0 && rsp_payload.found_level == '0))
      else $error("failed request returned an item");

   a_store_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("store read and write in the same cycle");

endmodule

### test/multilevel_wrap_queue_tb.sv
module multilevel_wrap_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mlwq_pkg::*;

   localparam int LEVEL_DEPTH = LEVEL_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 12;
   localparam int PHASE_BEATS = 96;
   // Level register per random phase, phase 0 in the low nibble
   localparam logic [4*PHASES-1:0] PHASE_LEVELS = 48'h816C_283F_0418;

   // Shadow of the per-level handle FIFOs and the replies they produce
   class level_queue_shadow;
      logic [ITEM_WIDTH-1:0]        handles [MAX_LEVELS][LEVEL_DEPTH];
      int unsigned                  head_idx [MAX_LEVELS];
      int unsigned                  fill [MAX_LEVELS];
      int unsigned                  stored;
      logic [LEVELS_USED_WIDTH-1:0] levels_reg;
      mlwq_rsp_type                 awaited [$];
      int unsigned                  errors;

      function new();
         foreach (head_idx[i]) begin
            head_idx[i] = 0;
            fill[i] = 0;
         end
         stored = 0;
         levels_reg = LEVELS_USED_WIDTH'(LEVELS_USED_RESET);
         errors = 0;
      endfunction

      function void write_levels(logic [LEVELS_USED_WIDTH-1:0] value);
         levels_reg = value;
      endfunction

      // Apply one accepted beat and queue the reply it must produce
      function void note_request(mlwq_req_type r);
         mlwq_rsp_type want;
         int unsigned  n;
         int unsigned  cur;
         int unsigned  slot;
         bit           hit;
         n = (levels_reg == 0) ? 1 : (levels_reg > MAX_LEVELS) ? MAX_LEVELS : levels_reg;
         want = '0;
         want.status = ST_OK;
         hit = 1'b0;
         if (r.level >= n) begin
            want.status = ST_RANGE;
         end else if (r.action == ACT_ENQUEUE) begin
            if (fill[r.level] >= LEVEL_DEPTH) begin
               want.status = ST_FULL;
            end else begin
               slot = (head_idx[r.level] + fill[r.level]) % LEVEL_DEPTH;
               handles[r.level][slot] = r.item_in;
               fill[r.level]++;
               stored++;
            end
         end else begin
            // Search upward from the start level, wrapping at the last level in use
            for (int i = 0; i < n && !hit; i++) begin
               cur = (r.level + i) % n;
               if (fill[cur] != 0) begin
                  want.item_out = handles[cur][head_idx[cur]];
                  want.found_level = cur[LEVEL_WIDTH-1:0];
                  head_idx[cur] = (head_idx[cur] + 1) % LEVEL_DEPTH;
                  fill[cur]--;
                  stored--;
                  hit = 1'b1;
               end
            end
            if (!hit) want.status = ST_EMPTY;
         end
         want.total_count = stored[TOTAL_WIDTH-1:0];
         awaited.push_back(want);
      endfunction

      // Compare a reply beat against the oldest expectation
      function void check_reply(mlwq_rsp_type got);
         mlwq_rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected reply, expected none, got %h", $time, got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status)
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
         if (got.found_level !== want.found_level)
            $display("%0t: found_level expected %0d got %0d",
                     $time, want.found_level, got.found_level);
         if (got.item_out !== want.item_out)
            $display("%0t: item_out expected %h got %h", $time, want.item_out, got.item_out);
         if (got.total_count !== want.total_count)
            $display("%0t: total_count expected %0d got %0d",
                     $time, want.total_count, got.total_count);
         if (got !== want) errors++;
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   mlwq_req_type                 req_payload = '0;
   logic                         rsp_valid;
   mlwq_rsp_type                 rsp_payload;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [LEVELS_USED_WIDTH-1:0] csr_data = '0;
   int unsigned                  cycle_count = 0;
   level_queue_shadow            board;

   multilevel_wrap_queue dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   // Watch the three channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_reply(rsp_payload);
         if (start && !busy) board.note_request(req_payload);
         if (csr_valid && csr_ready) board.write_levels(csr_data);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one beat and hold it until the block takes it; start stays high
   task automatic send_beat(input mlwq_action_type act, input logic [LEVEL_WIDTH-1:0] lvl,
                            input logic [ITEM_WIDTH-1:0] handle);
      mlwq_req_type beat;
      beat.action = act;
      beat.level = lvl;
      beat.item_in = handle;
      start <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start for the given number of cycles
   task automatic rest_idle(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and wait until every reply is in
   task automatic settle();
      start <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write the level register while the block is idle
   task automatic set_levels(input logic [LEVELS_USED_WIDTH-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int                           eff;
      int                           enq_pct;
      int                           lvl;
      logic [LEVELS_USED_WIDTH-1:0] cfg;
      logic [ITEM_WIDTH-1:0]        handle;
      mlwq_action_type              act;

      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty queue, both ends of the level range
      send_beat(ACT_DEQUEUE, 3'd0, '0);
      send_beat(ACT_DEQUEUE, 3'd7, 32'h1234_5678);
      // Extreme handles at the lowest and highest level
      send_beat(ACT_ENQUEUE, 3'd0, '0);
      send_beat(ACT_ENQUEUE, 3'd7, '1);
      send_beat(ACT_ENQUEUE, 3'd3, 32'hA5A5_5A5A);
      // Search past the top level, then wrap back to level 0
      send_beat(ACT_DEQUEUE, 3'd5, '0);
      send_beat(ACT_DEQUEUE, 3'd4, '0);
      send_beat(ACT_DEQUEUE, 3'd3, '0);
      // Fill one level and push one more into the full FIFO
      for (int i = 0; i <= LEVEL_DEPTH; i++) send_beat(ACT_ENQUEUE, 3'd2, $urandom);

      // Shrink below the full level: its items stay counted but unreachable
      set_levels(4'd2);
      send_beat(ACT_DEQUEUE, 3'd1, '0);
      send_beat(ACT_ENQUEUE, 3'd2, 32'hDEAD_BEEF);
      send_beat(ACT_DEQUEUE, 3'd7, '0);
      // Zero acts as one level
      set_levels(4'd0);
      send_beat(ACT_ENQUEUE, 3'd1, 32'h0000_0001);
      send_beat(ACT_ENQUEUE, 3'd0, 32'h8000_0000);
      send_beat(ACT_DEQUEUE, 3'd0, '0);
      // Above the built maximum acts as the maximum
      set_levels(4'd15);
      send_beat(ACT_DEQUEUE, 3'd6, '0);

      // Random phases over a spread of level settings; no idling in the last
      for (int p = 0; p < PHASES; p++) begin
         cfg = PHASE_LEVELS[4*p +: 4];
         set_levels(cfg);
         eff = (cfg == 0) ? 1 : (cfg > MAX_LEVELS) ? MAX_LEVELS : int'(cfg);
         enq_pct = (p % 3 == 0) ? 75 : (p % 3 == 1) ? 50 : 30;
         for (int k = 0; k < PHASE_BEATS; k++) begin
            if (p < PHASES - 1 && $urandom_range(0, 3) == 0) rest_idle($urandom_range(1, 6));
            if ($urandom_range(0, 5) == 0) lvl = $urandom_range(0, 7);
            else lvl = $urandom_range(0, eff - 1);
            case ($urandom_range(0, 15))
               0: handle = '0;
               1: handle = '1;
               default: handle = $urandom;
            endcase
            if ($urandom_range(0, 99) < enq_pct) act = ACT_ENQUEUE;
            else act = ACT_DEQUEUE;
            send_beat(act, lvl[LEVEL_WIDTH-1:0], handle);
         end
      end

      settle();
      repeat (4) @(posedge clock);
      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
sv/mlwq_pkg.sv
sv/mlwq_store.sv
sv/mlwq_ctrl.sv
sv/multilevel_wrap_queue.sv
test/multilevel_wrap_queue_tb.sv
